// File: hdl/smx_pkg.sv
// smx_pkg: shared types, sizes and codes of the sample voice mixer
// used by smx_ram users and sample_voice_mixer_top; no dependencies
package smx_pkg;

    localparam int MAX_VOICES  = 16;
    localparam int MAX_SOUNDS  = 16;
    localparam int STORE_WORDS = 65536;

    localparam int SMP_W  = 16;
    localparam int GAIN_W = 16;
    localparam int AW     = $clog2(STORE_WORDS);
    localparam int POS_W  = $clog2(STORE_WORDS + 1);
    localparam int VIDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int SIDX_W = (MAX_SOUNDS > 1) ? $clog2(MAX_SOUNDS) : 1;
    localparam int ID_W   = 5;
    localparam int NID_W  = $clog2(MAX_SOUNDS + 2);
    localparam int PROD_W = SMP_W + GAIN_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(MAX_VOICES) + 1;

    typedef enum logic [2:0] {
        F_LOAD  = 3'd0,
        F_CLOSE = 3'd1,
        F_PLAY  = 3'd2,
        F_STOP  = 3'd3,
        F_TICK  = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_UNKNOWN     = 3'd1,
        ST_VOICES_FULL = 3'd2,
        ST_MEM_FULL    = 3'd3,
        ST_TABLE_FULL  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VCHK,
        S_MUL0,
        S_ACC0,
        S_ACC1,
        S_ADV,
        S_FIN
    } t_state;

    // round half up to q1.15 and saturate
    function automatic logic signed [SMP_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] r;
        begin
            r = (acc + ACC_W'(16384)) >>> 15;
            if (r > ACC_W'(32767)) begin
                finish = 16'sh7fff;
            end else if (r < -ACC_W'(32768)) begin
                finish = 16'sh8000;
            end else begin
                finish = r[SMP_W-1:0];
            end
        end
    endfunction

endpackage

// File: hdl/smx_ram.sv
// smx_ram: generic single write port, single read port ram
// registered read data; no dependencies
module smx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hdl/sample_voice_mixer_top.sv
// sample_voice_mixer_top: sound memory, sound table, voices and tick mixer
// depends on smx_pkg and smx_ram
//
//  channel  | ports                                           | handshake
//  ---------+-------------------------------------------------+--------------------------
//  command  | i_func i_pcm_sample i_is_stereo i_sound_id i_gain | i_start high, o_busy low
//  result   | o_status o_left_out o_right_out o_new_id        | o_done, one cycle
//
// load, close, play, stop and unused codes: result is registered, shown in the cycle after the transaction
// tick: each voice takes S_VCHK, an active one then S_MUL0, S_ACC0, S_ACC1 (stereo only) and S_ADV;
// S_FIN ends the tick; the steps are set by the one sample memory read port and the shared multiplier
// o_busy is high only during a tick; synchronous active-low reset
// the receiver cannot stall: each result shows for exactly one cycle
module sample_voice_mixer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [2:0]                       i_func,
    input  logic signed [smx_pkg::SMP_W-1:0] i_pcm_sample,
    input  logic                             i_is_stereo,
    input  logic [smx_pkg::ID_W-1:0]         i_sound_id,
    input  logic [smx_pkg::GAIN_W-1:0]       i_gain,
    output logic                             o_done,
    output logic [2:0]                       o_status,
    output logic signed [smx_pkg::SMP_W-1:0] o_left_out,
    output logic signed [smx_pkg::SMP_W-1:0] o_right_out,
    output logic [smx_pkg::ID_W-1:0]         o_new_id
);
    import smx_pkg::*;

    t_state r_state, n_state;

    logic [POS_W-1:0]  r_fill;
    logic [POS_W-1:0]  r_open_base;
    logic [NID_W-1:0]  r_next_id;
    logic [POS_W-1:0]  r_snd_base   [MAX_SOUNDS];
    logic [POS_W-1:0]  r_snd_len    [MAX_SOUNDS];
    logic              r_snd_stereo [MAX_SOUNDS];
    logic [MAX_VOICES-1:0] r_von;
    logic [SIDX_W-1:0] r_vsnd  [MAX_VOICES];
    logic [POS_W-1:0]  r_vpos  [MAX_VOICES];
    logic [GAIN_W-1:0] r_vgain [MAX_VOICES];

    logic [VIDX_W-1:0]       r_vidx;
    logic signed [ACC_W-1:0] r_accl, r_accr;
    logic signed [PROD_W-1:0] r_prod;

    logic              r_done;
    logic [2:0]        r_status;
    logic signed [SMP_W-1:0] r_left, r_right;
    logic [ID_W-1:0]   r_new_id;

    logic accept;
    logic [SMP_W-1:0] ram_rdata;
    logic [AW-1:0]    ram_raddr;
    logic             ram_we;

    // current voice view
    logic [SIDX_W-1:0] cur_snd;
    logic [POS_W-1:0]  cur_len, cur_pos, cur_base, adv_pos;
    logic              cur_st;
    logic [POS_W-1:0]  need;
    logic              end_now, end_adv;
    logic [POS_W:0]    rem_now, rem_adv;
    logic signed [PROD_W-1:0] mul;

    // play: lowest free voice
    logic              free_found;
    logic [VIDX_W-1:0] free_idx;
    logic              id_bad;

    assign accept = i_start && !o_busy;
    assign ram_we = accept && (i_func == F_LOAD) && (r_fill < POS_W'(STORE_WORDS));

    smx_ram #(.WIDTH(SMP_W), .DEPTH(STORE_WORDS)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_pcm_sample),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cur_snd  = r_vsnd[r_vidx];
    assign cur_len  = r_snd_len[cur_snd];
    assign cur_base = r_snd_base[cur_snd];
    assign cur_st   = r_snd_stereo[cur_snd];
    assign cur_pos  = r_vpos[r_vidx];
    assign need     = cur_st ? POS_W'(2) : POS_W'(1);
    assign adv_pos  = cur_pos + need;
    assign rem_now  = {1'b0, cur_len} - {1'b0, cur_pos};
    assign rem_adv  = {1'b0, cur_len} - {1'b0, adv_pos};
    assign end_now  = rem_now[POS_W] || (rem_now[POS_W-1:0] < need);
    assign end_adv  = rem_adv[POS_W] || (rem_adv[POS_W-1:0] < need);
    assign mul      = $signed(ram_rdata) * $signed({1'b0, r_vgain[r_vidx]});

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int v = MAX_VOICES - 1; v >= 0; v--) begin
            if (!r_von[v]) begin
                free_found = 1'b1;
                free_idx   = VIDX_W'(v);
            end
        end
    end

    assign id_bad = (i_sound_id == '0) || ({1'b0, i_sound_id} >= (ID_W+1)'(r_next_id))
                    || (i_sound_id > ID_W'(MAX_SOUNDS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_func == F_TICK) n_state = S_VCHK;
            end
            S_VCHK: begin
                if (r_von[r_vidx] && !end_now) begin
                    n_state = S_MUL0;
                end else if (r_vidx == VIDX_W'(MAX_VOICES - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_MUL0: n_state = S_ACC0;
            S_ACC0: n_state = cur_st ? S_ACC1 : S_ADV;
            S_ACC1: n_state = S_ADV;
            S_ADV: begin
                n_state = (r_vidx == VIDX_W'(MAX_VOICES - 1)) ? S_FIN : S_VCHK;
            end
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        case (r_state)
            S_VCHK:  ram_raddr = AW'(cur_base + cur_pos);
            S_MUL0:  ram_raddr = AW'(cur_base + cur_pos + POS_W'(1));
            default: ram_raddr = AW'(cur_base + cur_pos);
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_open_base <= '0;
            r_next_id   <= NID_W'(1);
            r_von       <= '0;
            r_done      <= 1'b0;
            r_vidx      <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (accept) begin
                r_status <= ST_OK;
                r_left   <= '0;
                r_right  <= '0;
                r_new_id <= '0;
                r_done   <= (i_func != F_TICK);
                case (i_func)
                    F_LOAD: begin
                        if (r_fill < POS_W'(STORE_WORDS)) begin
                            r_fill <= r_fill + POS_W'(1);
                        end else begin
                            r_status <= ST_MEM_FULL;
                        end
                    end
                    F_CLOSE: begin
                        if (r_next_id > NID_W'(MAX_SOUNDS)) begin
                            r_status <= ST_TABLE_FULL;
                        end else begin
                            r_snd_base[SIDX_W'(r_next_id - NID_W'(1))]   <= r_open_base;
                            r_snd_len[SIDX_W'(r_next_id - NID_W'(1))]    <= r_fill - r_open_base;
                            r_snd_stereo[SIDX_W'(r_next_id - NID_W'(1))] <= i_is_stereo;
                            r_open_base <= r_fill;
                            r_new_id    <= ID_W'(r_next_id);
                            r_next_id   <= r_next_id + NID_W'(1);
                        end
                    end
                    F_PLAY: begin
                        if (id_bad) begin
                            r_status <= ST_UNKNOWN;
                        end else if (!free_found) begin
                            r_status <= ST_VOICES_FULL;
                        end else begin
                            r_von[free_idx]   <= 1'b1;
                            r_vsnd[free_idx]  <= SIDX_W'(i_sound_id - ID_W'(1));
                            r_vpos[free_idx]  <= '0;
                            r_vgain[free_idx] <= i_gain;
                        end
                    end
                    F_STOP: r_von <= '0;
                    F_TICK: begin
                        r_vidx <= '0;
                        r_accl <= '0;
                        r_accr <= '0;
                    end
                    default: ;
                endcase
            end
            case (r_state)
                S_VCHK: begin
                    if (r_von[r_vidx] && end_now) r_von[r_vidx] <= 1'b0;
                    if (!(r_von[r_vidx] && !end_now)) r_vidx <= r_vidx + VIDX_W'(1);
                end
                S_MUL0: r_prod <= mul;
                S_ACC0: begin
                    r_accl <= r_accl + ACC_W'(r_prod);
                    if (cur_st) begin
                        r_prod <= mul;
                    end else begin
                        r_accr <= r_accr + ACC_W'(r_prod);
                    end
                end
                S_ACC1: r_accr <= r_accr + ACC_W'(r_prod);
                S_ADV: begin
                    r_vpos[r_vidx] <= adv_pos;
                    if (end_adv) r_von[r_vidx] <= 1'b0;
                    r_vidx <= r_vidx + VIDX_W'(1);
                end
                S_FIN: begin
                    r_left   <= finish(r_accl);
                    r_right  <= finish(r_accr);
                    r_status <= ST_OK;
                    r_new_id <= '0;
                    r_done   <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_left_out  = r_left;
    assign o_right_out = r_right;
    assign o_new_id    = r_new_id;

`ifndef SYNTH
    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> o_done)
        else $error("tick finished without a result");
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == F_TICK) |=> o_busy && !o_done)
        else $error("tick transaction did not start the mixer");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= POS_W'(STORE_WORDS) && r_open_base <= r_fill)
        else $error("fill pointer out of range");
    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id >= NID_W'(1) && r_next_id <= NID_W'(MAX_SOUNDS + 1))
        else $error("next sound id out of range");
`endif
endmodule
